// ----- rtl/core/bdpc_pkg.sv -----
package bdpc_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int CFG_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_DEBOUNCE_TIME = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LONG_PRESS_TIME = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESSED_IS_LOW = 2'd2;

   localparam logic [CFG_WIDTH-1:0] DEBOUNCE_TIME_RESET = 16'd110;
   localparam logic [CFG_WIDTH-1:0] LONG_PRESS_TIME_RESET = 16'd800;
   localparam logic PRESSED_IS_LOW_RESET = 1'b1;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_SHORT = 2'd1,
      EV_LONG  = 2'd2
   } event_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0] now_ms;
      logic                  level;
   } poll_type;

endpackage

// ----- rtl/core/button_debounce_press_classifier_top.sv -----
// Button debounce and short/long press classifier. Each req transfer is one
// poll (millisecond timestamp and raw pin level) and yields exactly one rsp
// transfer carrying an event code: 0 none, 1 short press on release, 2 long
// press while held. Polls are taken one per clock while rsp_ready is high; a
// result is offered once its poll has passed the input register, where the
// combinational classify logic works on it, and then the result register,
// which takes the event once it has room. Results come out in poll order, and a
// stalled rsp side holds polls back. Time differences wrap modulo 2^32. Write
// debounce_time (index 0), long_press_time (index 1) and pressed_is_low
// (index 2) only while no poll is in flight; other indexes are ignored.
module button_debounce_press_classifier_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bdpc_pkg::TIME_WIDTH-1:0]      req_now_ms,
   input  logic                                 req_level,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [1:0]                           rsp_press_event,
   input  logic                                 csr_write_en,
   input  logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdpc_pkg::CFG_WIDTH-1:0]       csr_write_data
);
   import bdpc_pkg::*;

   logic      item_valid;
   poll_type  item;
   logic      out_free;
   logic      take;
   event_type press_event;

   // a poll moves on once the result register has room
   assign take = item_valid && out_free;

   bdpc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_now_ms (req_now_ms),
      .req_level  (req_level),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   bdpc_classify u_classify (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .take           (take),
      .item           (item),
      .press_event    (press_event)
   );

   bdpc_out_stage u_out_stage (
      .clock           (clock),
      .reset           (reset),
      .load            (take),
      .press_event     (press_event),
      .out_free        (out_free),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_press_event (rsp_press_event)
   );

endmodule

// ----- rtl/core/bdpc_in_stage.sv -----
module bdpc_in_stage (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [bdpc_pkg::TIME_WIDTH-1:0]  req_now_ms,
   input  logic                             req_level,
   input  logic                             take,
   output logic                             item_valid,
   output bdpc_pkg::poll_type               item
);
   import bdpc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   poll_type poll_ff;
   logic     load;

   assign req_ready = !valid_ff || take;
   assign load = req_valid && req_ready;
   assign valid_in = load || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         poll_ff.now_ms <= req_now_ms;
         poll_ff.level <= req_level;
      end
   end

   assign item_valid = valid_ff;
   assign item = poll_ff;

endmodule

// ----- rtl/core/bdpc_classify.sv -----
module bdpc_classify (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_en,
   input  logic [bdpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bdpc_pkg::CFG_WIDTH-1:0]       csr_write_data,
   input  logic                                 take,
   input  bdpc_pkg::poll_type                   item,
   output bdpc_pkg::event_type                  press_event
);
   import bdpc_pkg::*;

   logic [CFG_WIDTH-1:0]  debounce_time_ff;
   logic [CFG_WIDTH-1:0]  long_press_time_ff;
   logic                  pressed_is_low_ff;

   logic                  last_raw_ff, last_raw_in;
   logic [TIME_WIDTH-1:0] change_time_ff, change_time_in;
   logic                  stable_level_ff, stable_level_in;
   logic [TIME_WIDTH-1:0] press_start_ff, press_start_in;
   logic                  long_reported_ff, long_reported_in;

   logic [TIME_WIDTH-1:0] since_change;
   logic [TIME_WIDTH-1:0] since_press;
   logic                  bouncing;
   logic                  pressed_now;
   event_type             event_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_time_ff <= DEBOUNCE_TIME_RESET;
         long_press_time_ff <= LONG_PRESS_TIME_RESET;
         pressed_is_low_ff <= PRESSED_IS_LOW_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE_TIME:   debounce_time_ff <= csr_write_data;
            CSR_LONG_PRESS_TIME: long_press_time_ff <= csr_write_data;
            CSR_PRESSED_IS_LOW:  pressed_is_low_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      last_raw_in = item.level;
      change_time_in = (item.level != last_raw_ff) ? item.now_ms : change_time_ff;
      since_change = item.now_ms - change_time_in;
      bouncing = since_change < {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, debounce_time_ff};

      stable_level_in = stable_level_ff;
      press_start_in = press_start_ff;
      long_reported_in = long_reported_ff;
      event_val = EV_NONE;
      pressed_now = (item.level != pressed_is_low_ff);
      since_press = '0;

      if (!bouncing) begin
         if (stable_level_ff != item.level) begin
            stable_level_in = item.level;
            if (pressed_now) begin
               press_start_in = item.now_ms;
               long_reported_in = 1'b0;
            end else if (!long_reported_ff) begin
               event_val = EV_SHORT;
            end
         end
         // long press check on the level as it stands after this poll
         since_press = item.now_ms - press_start_in;
         if (event_val == EV_NONE && (stable_level_in != pressed_is_low_ff)
               && !long_reported_in
               && since_press >= {{(TIME_WIDTH-CFG_WIDTH){1'b0}}, long_press_time_ff}) begin
            long_reported_in = 1'b1;
            event_val = EV_LONG;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff <= !PRESSED_IS_LOW_RESET ? 1'b0 : 1'b1;
         change_time_ff <= '0;
         stable_level_ff <= !PRESSED_IS_LOW_RESET ? 1'b0 : 1'b1;
         press_start_ff <= '0;
         long_reported_ff <= 1'b0;
      end else if (take) begin
         last_raw_ff <= last_raw_in;
         change_time_ff <= change_time_in;
         stable_level_ff <= stable_level_in;
         press_start_ff <= press_start_in;
         long_reported_ff <= long_reported_in;
      end
   end

   assign press_event = event_val;

`ifndef ASSERT_OFF
   a_long_sets_flag: assert property (@(posedge clock) disable iff (reset)
      take && event_val == EV_LONG |=> long_reported_ff)
      else $error("long press left the reported flag clear");

   a_short_needs_no_long: assert property (@(posedge clock) disable iff (reset)
      take && event_val == EV_SHORT |-> !long_reported_ff && stable_level_ff != item.level)
      else $error("short press without a stable release");

   a_idle_holds_state: assert property (@(posedge clock) disable iff (reset)
      !take |=> $stable(stable_level_ff) && $stable(press_start_ff)
         && $stable(long_reported_ff))
      else $error("press state moved without a transfer");

   a_bounce_no_event: assert property (@(posedge clock) disable iff (reset)
      take && bouncing |-> event_val == EV_NONE)
      else $error("event reported while the level is still bouncing");
`endif

endmodule

// ----- rtl/core/bdpc_out_stage.sv -----
module bdpc_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  bdpc_pkg::event_type press_event,
   output logic                out_free,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_press_event
);
   import bdpc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   event_type event_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         event_ff <= press_event;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_press_event = event_ff;

endmodule
